/* src/deque_with_key_delete_and_dump_macros.svh */
// Assertion macros for the deque checker.
// Expects clk_i and rst_ni in the scope of use.
`ifndef DEQUE_WITH_KEY_DELETE_AND_DUMP_MACROS_SVH
`define DEQUE_WITH_KEY_DELETE_AND_DUMP_MACROS_SVH

// Plain clocked property, disabled during reset.
`define DQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Signal must hold its value in the cycle after cond.
`define DQ_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    cond |=> $stable(sig)) else $error(msg);

`endif

/* src/deq_pkg.sv */
// Shared types and constants of the deque block.
// No dependencies.
`default_nettype none

package deq_pkg;

  localparam int FUNC_W      = 4;
  localparam int KEY_W       = 32;
  localparam int COUNT_W     = 6;
  localparam int STATUS_W    = 2;
  localparam int MAX_RESULTS = 32;

  typedef enum logic [FUNC_W-1:0] {
    F_APPEND     = 4'd0,
    F_PUSH_FRONT = 4'd1,
    F_DROP_FRONT = 4'd2,
    F_DROP_BACK  = 4'd3,
    F_DEL_KEY    = 4'd4,
    F_DUMP_ALL   = 4'd5,
    F_DUMP_FIRST = 4'd6,
    F_DUMP_LAST  = 4'd7,
    F_CLEAR      = 4'd8
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [KEY_W-1:0] value;
    logic                    has_value;
    logic                    last_of_run;
    status_e                 status;
  } res_t;

endpackage

`default_nettype wire

/* src/deq_if.sv */
// Valid/ready channel interfaces for operations and results.
// Depends on deq_pkg.
`default_nettype none

interface deq_in_if import deq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [FUNC_W-1:0]  func;
  logic signed [KEY_W-1:0]   key;
  logic        [COUNT_W-1:0] count;

  modport source (output valid, func, key, count, input ready);
  modport sink   (input valid, func, key, count, output ready);
endinterface

interface deq_out_if import deq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [KEY_W-1:0]    value;
  logic                       has_value;
  logic                       last_of_run;
  logic        [STATUS_W-1:0] status;

  modport source (output valid, value, has_value, last_of_run, status, input ready);
  modport sink   (input valid, value, has_value, last_of_run, status, output ready);
endinterface

`default_nettype wire

/* src/deq_ram.sv */
// Entry store: one write port, one read port, registered read data.
// Depends on deq_pkg.
`default_nettype none

module deq_ram import deq_pkg::*; #(
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic signed [KEY_W-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [AW-1:0]           raddr_i,
  output logic signed [KEY_W-1:0] rdata_o
);

  logic signed [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* src/deq_obuf.sv */
// Output register between the sequencer and the result channel.
// Depends on deq_pkg and deq_if.
`default_nettype none

module deq_obuf import deq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      push_ready_o,
  input  res_t      res_i,
  deq_out_if.source out_ch
);

  logic valid_q;
  res_t data_q;

  assign push_ready_o = !valid_q || out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_ready_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && push_ready_o) begin
      data_q <= res_i;
    end
  end

  assign out_ch.valid       = valid_q;
  assign out_ch.value       = data_q.value;
  assign out_ch.has_value   = data_q.has_value;
  assign out_ch.last_of_run = data_q.last_of_run;
  assign out_ch.status      = data_q.status;

endmodule

`default_nettype wire

/* src/deque_with_key_delete_and_dump.sv */
// Deque top level: operation sequencer around the entry store and output register.
// Depends on deq_pkg, deq_if, deq_ram and deq_obuf.
//
// Bounded double-ended store of DEPTH signed 32-bit keys held as a ring in a
// single-port-read, single-port-write memory. One operation is taken at a
// time. Inserts, drops, clear and unknown codes are a transfer followed by an
// acknowledge. Delete-by-key walks the live entries one memory read per cycle
// and compacts the survivors in place. A dump of n entries streams one result
// per cycle from the registered read port while the result channel is ready,
// at most MAX_RESULTS entries per dump; backpressure on the result channel
// stalls the dump. No clearing pass is needed after reset.
`default_nettype none

module deque_with_key_delete_and_dump import deq_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int MW = (CW > COUNT_W) ? CW : COUNT_W;

  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [CW-1:0] LIM_C     = CW'((DEPTH > MAX_RESULTS) ? MAX_RESULTS : DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACK  = 2'd1;
  localparam logic [1:0] S_DEL  = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [1:0]              state_q, state_d;
  logic [AW-1:0]           head_q, head_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           wr_q, wr_d;
  logic [CW-1:0]           n_q, n_d;
  logic [CW-1:0]           base_q, base_d;
  logic                    pend_q, pend_d;
  status_e                 ack_st_q, ack_st_d;
  logic signed [KEY_W-1:0] key_q, key_d;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic signed [KEY_W-1:0] ram_wdata, ram_rdata;

  logic    push, obuf_rdy;
  res_t    res;
  logic    in_xfer;
  logic [MW-1:0] cnt_ext, cq_ext;
  logic [CW-1:0] n_raw, n_sel;
  logic [AW-1:0] head_m1;

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign cnt_ext     = MW'(in_ch.count);
  assign cq_ext      = MW'(count_q);
  assign head_m1     = (head_q == '0) ? LAST_SLOT : head_q - AW'(1);

  // last-n start uses the unclamped count; the result limit applies after
  always_comb begin
    n_raw = (cnt_ext < cq_ext) ? cnt_ext[CW-1:0] : count_q;
    if (in_ch.func == F_DUMP_ALL) begin
      n_raw = count_q;
    end
    n_sel = (n_raw > LIM_C) ? LIM_C : n_raw;
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    wr_d      = wr_q;
    n_d       = n_q;
    base_d    = base_q;
    pend_d    = pend_q;
    ack_st_d  = ack_st_q;
    key_d     = key_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = in_ch.key;
    ram_re    = 1'b0;
    ram_raddr = '0;
    push      = 1'b0;
    res       = '{value: '0, has_value: 1'b0, last_of_run: 1'b1, status: ack_st_q};

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d  = S_ACK;
          ack_st_d = ST_OK;
          case (in_ch.func)
            F_APPEND: begin
              if (count_q == DEPTH_C) begin
                ack_st_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(head_q, count_q);
                count_d   = count_q + CW'(1);
              end
            end
            F_PUSH_FRONT: begin
              if (count_q == DEPTH_C) begin
                ack_st_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = head_m1;
                head_d    = head_m1;
                count_d   = count_q + CW'(1);
              end
            end
            F_DROP_FRONT: begin
              if (count_q == '0) begin
                ack_st_d = ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
                if (count_q == CW'(1) || head_q == LAST_SLOT) begin
                  head_d = '0;
                end else begin
                  head_d = head_q + AW'(1);
                end
              end
            end
            F_DROP_BACK: begin
              if (count_q == '0) begin
                ack_st_d = ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
                if (count_q == CW'(1)) begin
                  head_d = '0;
                end
              end
            end
            F_DEL_KEY: begin
              if (count_q == '0) begin
                ack_st_d = ST_EMPTY;
              end else begin
                key_d   = in_ch.key;
                idx_d   = '0;
                wr_d    = '0;
                pend_d  = 1'b0;
                state_d = S_DEL;
              end
            end
            F_DUMP_ALL, F_DUMP_FIRST, F_DUMP_LAST: begin
              if (count_q == '0) begin
                ack_st_d = ST_EMPTY;
              end else if (n_sel != '0) begin
                n_d     = n_sel;
                base_d  = (in_ch.func == F_DUMP_LAST) ? count_q - n_raw : '0;
                idx_d   = '0;
                pend_d  = 1'b0;
                state_d = S_DUMP;
              end
            end
            F_CLEAR: begin
              head_d  = '0;
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_ACK: begin
        push = 1'b1;
        if (obuf_rdy) begin
          state_d = S_IDLE;
        end
      end

      // read entry idx, write survivors at wr; writes never pass the read index
      S_DEL: begin
        if (pend_q && ram_rdata != key_q) begin
          ram_we    = 1'b1;
          ram_waddr = slot_of(head_q, wr_q);
          ram_wdata = ram_rdata;
          wr_d      = wr_q + CW'(1);
        end
        if (idx_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = slot_of(head_q, idx_q);
          idx_d     = idx_q + CW'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d   = 1'b0;
          count_d  = wr_d;
          if (wr_d == '0) begin
            head_d = '0;
          end
          ack_st_d = ST_OK;
          state_d  = S_ACK;
        end
      end

      S_DUMP: begin
        push = pend_q;
        res  = '{value: ram_rdata, has_value: 1'b1, last_of_run: (idx_q == n_q),
                 status: ST_OK};
        if (!pend_q || obuf_rdy) begin
          if (idx_q < n_q) begin
            ram_re    = 1'b1;
            ram_raddr = slot_of(head_q, base_q + idx_q);
            idx_d     = idx_q + CW'(1);
            pend_d    = 1'b1;
          end else begin
            pend_d  = 1'b0;
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      wr_q     <= '0;
      n_q      <= '0;
      base_q   <= '0;
      pend_q   <= 1'b0;
      ack_st_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      wr_q     <= wr_d;
      n_q      <= n_d;
      base_q   <= base_d;
      pend_q   <= pend_d;
      ack_st_q <= ack_st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  deq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  deq_obuf u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (obuf_rdy),
    .res_i        (res),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire

/* src/deq_checker.sv */
// Port-level checks of the deque top level, bound to it below.
// Depends on deq_pkg and the assertion macro header.
`default_nettype none

`include "deque_with_key_delete_and_dump_macros.svh"

module deq_checker import deq_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire logic [KEY_W-1:0]    out_value_i,
  input wire logic                out_has_value_i,
  input wire logic                out_last_i,
  input wire logic [STATUS_W-1:0] out_status_i
);

  `DQ_ASSERT_HOLD(a_out_hold, out_valid_i && !out_ready_i, out_value_i, "result moved")
  `DQ_ASSERT(a_one_op, in_valid_i && in_ready_i |=> !in_ready_i, "op taken while busy")
  `DQ_ASSERT(a_run_body, out_valid_i && !out_last_i |-> out_has_value_i, "unmarked empty result")
  `DQ_ASSERT(a_value_ok, out_valid_i && out_has_value_i |-> out_status_i == ST_OK, "bad status")

endmodule

bind deque_with_key_delete_and_dump deq_checker u_deq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_ch.valid),
  .in_ready_i      (in_ch.ready),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .out_value_i     (out_ch.value),
  .out_has_value_i (out_ch.has_value),
  .out_last_i      (out_ch.last_of_run),
  .out_status_i    (out_ch.status)
);

`default_nettype wire

/* tb/tb_deque_with_key_delete_and_dump.sv */
// Testbench for deque_with_key_delete_and_dump: directed and random operations,
// checked result by result against a behavioral mirror of the store.
// Depends on deq_pkg, deq_if and the deque RTL.
`default_nettype none

module tb_deque_with_key_delete_and_dump;
  import deq_pkg::*;

  localparam int DEPTH = 32;
  localparam logic [FUNC_W-1:0] F_UNDEF_LO = 4'd9;
  localparam logic [FUNC_W-1:0] F_UNDEF_HI = 4'd15;

  logic clk_i;
  logic rst_ni;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  deque_with_key_delete_and_dump #(.DEPTH(DEPTH)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Mirror of the store
  logic signed [KEY_W-1:0] mirror [DEPTH];
  int unsigned             front_idx;
  int unsigned             fill;
  res_t                    pending_results [$];

  int  errors;
  bit  jitter_on;
  int  stall_left;
  res_t want;

  always #6 clk_i = ~clk_i;

  function automatic int unsigned ring_pos(int unsigned i);
    return (front_idx + i) % DEPTH;
  endfunction

  function automatic void queue_result(logic signed [KEY_W-1:0] v, logic hv, logic last,
                                       status_e st);
    res_t r;
    r.value       = v;
    r.has_value   = hv;
    r.last_of_run = last;
    r.status      = st;
    pending_results.push_back(r);
  endfunction

  function automatic void queue_dump(int unsigned start, int unsigned n);
    if (fill == 0) begin
      queue_result('0, 1'b0, 1'b1, ST_EMPTY);
    end else if (n == 0) begin
      queue_result('0, 1'b0, 1'b1, ST_OK);
    end else begin
      if (n > MAX_RESULTS) n = MAX_RESULTS;
      for (int unsigned i = 0; i < n; i++)
        queue_result(mirror[ring_pos(start + i)], 1'b1, (i + 1 == n), ST_OK);
    end
  endfunction

  function automatic void apply_op(logic [FUNC_W-1:0] f, logic signed [KEY_W-1:0] k,
                                   logic [COUNT_W-1:0] c);
    int unsigned n;
    int unsigned w;
    logic signed [KEY_W-1:0] v;
    n = (c < fill) ? c : fill;
    case (f)
      F_APPEND, F_PUSH_FRONT: begin
        if (fill >= DEPTH) begin
          queue_result('0, 1'b0, 1'b1, ST_FULL);
        end else begin
          if (f == F_APPEND) begin
            mirror[ring_pos(fill)] = k;
          end else begin
            front_idx = (front_idx + DEPTH - 1) % DEPTH;
            mirror[front_idx] = k;
          end
          fill++;
          queue_result('0, 1'b0, 1'b1, ST_OK);
        end
      end
      F_DROP_FRONT, F_DROP_BACK: begin
        if (fill == 0) begin
          queue_result('0, 1'b0, 1'b1, ST_EMPTY);
        end else begin
          if (f == F_DROP_FRONT) front_idx = (front_idx + 1) % DEPTH;
          fill--;
          if (fill == 0) front_idx = 0;
          queue_result('0, 1'b0, 1'b1, ST_OK);
        end
      end
      F_DEL_KEY: begin
        if (fill == 0) begin
          queue_result('0, 1'b0, 1'b1, ST_EMPTY);
        end else begin
          w = 0;
          for (int unsigned i = 0; i < fill; i++) begin
            v = mirror[ring_pos(i)];
            if (v != k) begin
              mirror[ring_pos(w)] = v;
              w++;
            end
          end
          fill = w;
          if (fill == 0) front_idx = 0;
          queue_result('0, 1'b0, 1'b1, ST_OK);
        end
      end
      F_DUMP_ALL:   queue_dump(0, fill);
      F_DUMP_FIRST: queue_dump(0, n);
      F_DUMP_LAST:  queue_dump(fill - n, n);
      F_CLEAR: begin
        front_idx = 0;
        fill      = 0;
        queue_result('0, 1'b0, 1'b1, ST_OK);
      end
      default: queue_result('0, 1'b0, 1'b1, ST_OK);
    endcase
  endfunction

  task automatic send_op(input logic [FUNC_W-1:0] f, input logic signed [KEY_W-1:0] k,
                         input logic [COUNT_W-1:0] c);
    int gap;
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.key   <= k;
    in_ch.count <= c;
    do @(posedge clk_i); while (!in_ch.ready);
    apply_op(f, k, c);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 3) == 0) return $urandom;
    case ($urandom_range(0, 5))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2:       return -1;
      3:       return 0;
      4:       return 7;
      default: return 42;
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (grow) begin
      if (r < 30) return F_APPEND;
      if (r < 50) return F_PUSH_FRONT;
      if (r < 57) return F_DROP_FRONT;
      if (r < 63) return F_DROP_BACK;
      if (r < 72) return F_DEL_KEY;
      if (r < 80) return F_DUMP_ALL;
      if (r < 88) return F_DUMP_FIRST;
      if (r < 97) return F_DUMP_LAST;
    end else begin
      if (r < 15) return F_APPEND;
      if (r < 25) return F_PUSH_FRONT;
      if (r < 42) return F_DROP_FRONT;
      if (r < 59) return F_DROP_BACK;
      if (r < 72) return F_DEL_KEY;
      if (r < 80) return F_DUMP_ALL;
      if (r < 88) return F_DUMP_FIRST;
      if (r < 96) return F_DUMP_LAST;
    end
    return F_CLEAR;
  endfunction

  task automatic check_empty_store();
    send_op(F_DROP_FRONT, 0, 0);
    send_op(F_DROP_BACK, 0, 0);
    send_op(F_DEL_KEY, -1, 0);
    send_op(F_DUMP_ALL, 0, 0);
    send_op(F_DUMP_FIRST, 0, 32);
    send_op(F_DUMP_LAST, 0, 1);
    send_op(F_UNDEF_LO, 32'sh7FFFFFFF, 32);
    send_op(F_UNDEF_HI, 32'sh80000000, 0);
  endtask

  task automatic check_basic_ops();
    send_op(F_APPEND, 32'sh7FFFFFFF, 0);
    send_op(F_PUSH_FRONT, 32'sh80000000, 0);
    send_op(F_APPEND, -1, 0);
    send_op(F_APPEND, -1, 0);
    send_op(F_PUSH_FRONT, -1, 0);
    send_op(F_APPEND, 5, 0);
    send_op(F_DUMP_ALL, 0, 0);
    send_op(F_DUMP_FIRST, 0, 0);
    send_op(F_DUMP_FIRST, 0, 2);
    send_op(F_DUMP_LAST, 0, 32);
    send_op(F_DEL_KEY, -1, 0);
    send_op(F_DEL_KEY, 1234, 0);
    send_op(F_DUMP_ALL, 0, 0);
    send_op(F_DROP_BACK, 0, 0);
    send_op(F_DROP_FRONT, 0, 0);
    send_op(F_DROP_BACK, 0, 0);
    send_op(F_PUSH_FRONT, 9, 0);
    send_op(F_DUMP_LAST, 0, 1);
    send_op(F_CLEAR, 0, 0);
    send_op(F_DUMP_ALL, 0, 0);
  endtask

  task automatic check_full_store();
    repeat (DEPTH)
      send_op($urandom_range(0, 1) ? F_APPEND : F_PUSH_FRONT, $urandom, 0);
    send_op(F_APPEND, 1, 0);
    send_op(F_PUSH_FRONT, 2, 0);
    send_op(F_DUMP_ALL, 0, 0);
    send_op(F_DUMP_LAST, 0, 5);
    send_op(F_DUMP_FIRST, 0, 32);
    send_op(F_DROP_FRONT, 0, 0);
    send_op(F_DUMP_LAST, 0, 32);
    send_op(F_CLEAR, 0, 0);
  endtask

  task automatic check_random_mix();
    for (int p = 0; p < 8; p++) begin
      jitter_on = (p < 6) && ($urandom_range(0, 3) != 0);
      repeat (20) send_op(pick_func(p % 2 == 0), pick_key(), COUNT_W'($urandom_range(0, 32)));
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%0d hv=%0b last=%0b st=%0d", $time,
                 out_ch.value, out_ch.has_value, out_ch.last_of_run, out_ch.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.value !== want.value || out_ch.has_value !== want.has_value ||
            out_ch.last_of_run !== want.last_of_run || out_ch.status !== want.status) begin
          $display("%0t: expected v=%0d hv=%0b l=%0b s=%0d, got v=%0d hv=%0b l=%0b s=%0d",
                   $time, want.value, want.has_value, want.last_of_run, want.status,
                   out_ch.value, out_ch.has_value, out_ch.last_of_run, out_ch.status);
          errors++;
        end
      end
    end
  end

  // Result backpressure in bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (jitter_on && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    #6_000_000;
    $display("[deque_with_key_delete_and_dump] ERROR");
    $finish;
  end

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.func   = '0;
    in_ch.key    = '0;
    in_ch.count  = '0;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    errors       = 0;
    front_idx    = 0;
    fill         = 0;
    jitter_on    = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    check_empty_store();
    check_basic_ops();
    check_full_store();
    check_random_mix();

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("[deque_with_key_delete_and_dump] OK");
    end else begin
      $display("[deque_with_key_delete_and_dump] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
